[rtl/core/asc_pkg.sv]
package asc_pkg;

  // Number of controller ports with a stored held word.
  localparam int PORT_COUNT = 2;
  localparam int PORT_W     = 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_DATA_W-1:0] DEAD_ZONE_RESET     = 7'd8;
  localparam logic [CFG_DATA_W-1:0] CENTER_OFFSET_RESET = 7'd6;
  localparam logic [CFG_DATA_W-1:0] RADIUS_LIMIT_RESET  = 7'd64;

  // Bit-serial steps of the shared compare-subtract unit.
  localparam int DIV_STEPS  = 30;
  localparam int SQRT_STEPS = 15;
  localparam int CNT_W      = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_ZONE     = 2'd0,
    REG_CENTER_OFFSET = 2'd1,
    REG_RADIUS_LIMIT  = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_XX,
    S_MUL_YY,
    S_MUL_LL,
    S_DECIDE,
    S_MUL_P,
    S_MUL_PP,
    S_DIV,
    S_SQRT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic              present;
    logic signed [7:0] raw_x;
    logic signed [7:0] raw_y;
    logic [15:0]       buttons;
  } asc_in_t;

  typedef struct packed {
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic [14:0]        magnitude;
    logic [15:0]        pressed;
    logic [15:0]        held;
  } asc_out_t;

endpackage

[rtl/core/analog_stick_conditioner_top.sv]
// Analog stick conditioner. Each input transaction is one gamepad sample for one port; it yields
// exactly one result transaction with dead-zoned, offset and radially clamped stick axes in Q.8,
// the vector length, and the newly pressed and held button words. One item is worked on at a
// time by a small sequencer around a shared 14x14 multiplier and a bit-serial compare-subtract
// unit that does both division and square root. A sample inside the radius limit, or from an
// absent controller, goes through three multiply steps, one compare step and 15 square-root
// steps before its result is loaded into the output register; a clamped sample instead follows
// the compare step with two multiply steps, a 30-step division and a 15-step square root for
// each axis. A new sample is accepted while the previous result still waits in the output
// register. Configuration registers are always ready; the radius limit is read while a
// sample is being worked on, so they should only be written between samples.
module analog_stick_conditioner_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  asc_pkg::asc_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output asc_pkg::asc_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [asc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [asc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  asc_pkg::state_t state_r, state_nxt;

  logic [6:0]  dead_zone_r, center_offset_r, radius_limit_r;
  logic [15:0] prev_held_r [asc_pkg::PORT_COUNT];

  logic [7:0]  ax_r, ay_r;
  logic        nx_r, ny_r;
  logic [15:0] pressed_r, held_r;
  logic [15:0] len_r;
  logic [13:0] limsq_r;
  logic        clamp_r;
  logic        axis_r;
  logic [13:0] p_r;
  logic [16:0] rem_r;
  logic [14:0] root_r;
  logic [29:0] work_r;
  logic [asc_pkg::CNT_W-1:0] cnt_r;
  logic [14:0] qx_r, qy_r, mag_r;

  logic              out_valid_r;
  asc_pkg::asc_out_t out_data_r;

  logic        in_fire;
  logic        port_ok;
  logic [15:0] held_in;
  logic [15:0] prev_in;
  logic [7:0]  axis_mag;
  logic [13:0] mul_a, mul_b;
  logic [27:0] prod;
  logic [18:0] sub_a, sub_b;
  logic [19:0] diff;
  logic        ge;
  logic        div_last, sqrt_last, out_load;

  function automatic logic [7:0] cond_axis(input logic [7:0] raw, input logic [6:0] dz,
                                           input logic [6:0] co);
    logic [7:0] a;
    a = raw[7] ? (8'd0 - raw) : raw;
    if (a == 8'd0 || a < {1'b0, dz} || {1'b0, co} >= a) begin
      return 8'd0;
    end
    return a - {1'b0, co};
  endfunction

  assign in_ready  = (state_r == asc_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign port_ok = (32'(in_data.port) < asc_pkg::PORT_COUNT);
  assign held_in = in_data.present ? in_data.buttons : 16'd0;
  assign prev_in = port_ok ? prev_held_r[in_data.port] : 16'd0;

  assign axis_mag  = axis_r ? ay_r : ax_r;
  assign div_last  = (cnt_r == asc_pkg::CNT_W'(asc_pkg::DIV_STEPS - 1));
  assign sqrt_last = (cnt_r == asc_pkg::CNT_W'(asc_pkg::SQRT_STEPS - 1));
  assign out_load  = (state_r == asc_pkg::S_DONE) && (!out_valid_r || out_ready);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = 14'd0;
    mul_b = 14'd0;
    case (state_r)
      asc_pkg::S_MUL_XX: begin
        mul_a = {6'd0, ax_r};
        mul_b = {6'd0, ax_r};
      end
      asc_pkg::S_MUL_YY: begin
        mul_a = {6'd0, ay_r};
        mul_b = {6'd0, ay_r};
      end
      asc_pkg::S_MUL_LL: begin
        mul_a = {7'd0, radius_limit_r};
        mul_b = {7'd0, radius_limit_r};
      end
      asc_pkg::S_MUL_P: begin
        mul_a = {6'd0, axis_mag};
        mul_b = {7'd0, radius_limit_r};
      end
      asc_pkg::S_MUL_PP: begin
        mul_a = p_r;
        mul_b = p_r;
      end
      default: begin
        mul_a = 14'd0;
        mul_b = 14'd0;
      end
    endcase
  end

  assign prod = 28'(mul_a) * 28'(mul_b);

  // Shared compare-subtract: one quotient bit or one root bit per cycle.
  always_comb begin
    if (state_r == asc_pkg::S_DIV) begin
      sub_a = {2'b00, rem_r[15:0], work_r[29]};
      sub_b = {3'b000, len_r};
    end else begin
      sub_a = {rem_r, work_r[29:28]};
      sub_b = {2'b00, root_r, 2'b01};
    end
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = !diff[19];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      asc_pkg::S_IDLE:   if (in_fire) state_nxt = asc_pkg::S_MUL_XX;
      asc_pkg::S_MUL_XX: state_nxt = asc_pkg::S_MUL_YY;
      asc_pkg::S_MUL_YY: state_nxt = asc_pkg::S_MUL_LL;
      asc_pkg::S_MUL_LL: state_nxt = asc_pkg::S_DECIDE;
      asc_pkg::S_DECIDE: begin
        state_nxt = (len_r > {2'b00, limsq_r}) ? asc_pkg::S_MUL_P : asc_pkg::S_SQRT;
      end
      asc_pkg::S_MUL_P:  state_nxt = asc_pkg::S_MUL_PP;
      asc_pkg::S_MUL_PP: state_nxt = asc_pkg::S_DIV;
      asc_pkg::S_DIV:    if (div_last) state_nxt = asc_pkg::S_SQRT;
      asc_pkg::S_SQRT: begin
        if (sqrt_last) begin
          state_nxt = (clamp_r && !axis_r) ? asc_pkg::S_MUL_P : asc_pkg::S_DONE;
        end
      end
      asc_pkg::S_DONE:   if (out_load) state_nxt = asc_pkg::S_IDLE;
      default:           state_nxt = asc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r     <= asc_pkg::DEAD_ZONE_RESET;
      center_offset_r <= asc_pkg::CENTER_OFFSET_RESET;
      radius_limit_r  <= asc_pkg::RADIUS_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        asc_pkg::REG_DEAD_ZONE:     dead_zone_r     <= cfg_data;
        asc_pkg::REG_CENTER_OFFSET: center_offset_r <= cfg_data;
        asc_pkg::REG_RADIUS_LIMIT:  radius_limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_held_r <= '{default: 16'd0};
    end else if (in_fire && port_ok) begin
      prev_held_r[in_data.port] <= held_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      asc_pkg::S_IDLE: begin
        if (in_fire) begin
          ax_r      <= in_data.present ?
                       cond_axis(in_data.raw_x, dead_zone_r, center_offset_r) : 8'd0;
          ay_r      <= in_data.present ?
                       cond_axis(in_data.raw_y, dead_zone_r, center_offset_r) : 8'd0;
          nx_r      <= in_data.raw_x[7];
          ny_r      <= in_data.raw_y[7];
          held_r    <= held_in;
          pressed_r <= held_in & ~prev_in;
          axis_r    <= 1'b0;
        end
      end
      asc_pkg::S_MUL_XX: len_r <= prod[15:0];
      asc_pkg::S_MUL_YY: len_r <= len_r + prod[15:0];
      asc_pkg::S_MUL_LL: limsq_r <= prod[13:0];
      asc_pkg::S_DECIDE: begin
        clamp_r <= (len_r > {2'b00, limsq_r});
        // The unclamped length is below 2^14, so its Q.16 square fits the radicand.
        rem_r   <= 17'd0;
        root_r  <= 15'd0;
        work_r  <= {len_r[13:0], 16'd0};
        cnt_r   <= '0;
      end
      asc_pkg::S_MUL_P: p_r <= prod[13:0];
      asc_pkg::S_MUL_PP: begin
        // The quotient stays below 2^30, so the top bits start as the partial remainder.
        rem_r  <= {3'b000, prod[27:14]};
        work_r <= {prod[13:0], 16'd0};
        cnt_r  <= '0;
      end
      asc_pkg::S_DIV: begin
        work_r <= {work_r[28:0], ge};
        if (div_last) begin
          rem_r  <= 17'd0;
          root_r <= 15'd0;
          cnt_r  <= '0;
        end else begin
          rem_r <= ge ? diff[16:0] : sub_a[16:0];
          cnt_r <= cnt_r + asc_pkg::CNT_W'(1);
        end
      end
      asc_pkg::S_SQRT: begin
        rem_r  <= ge ? diff[16:0] : sub_a[16:0];
        root_r <= {root_r[13:0], ge};
        work_r <= {work_r[27:0], 2'b00};
        cnt_r  <= cnt_r + asc_pkg::CNT_W'(1);
        if (sqrt_last) begin
          if (!clamp_r) begin
            qx_r  <= {ax_r[6:0], 8'd0};
            qy_r  <= {ay_r[6:0], 8'd0};
            mag_r <= {root_r[13:0], ge};
          end else if (!axis_r) begin
            qx_r   <= {root_r[13:0], ge};
            axis_r <= 1'b1;
          end else begin
            qy_r  <= {root_r[13:0], ge};
            mag_r <= {radius_limit_r, 8'd0};
          end
        end
      end
      asc_pkg::S_DONE: begin
        if (out_load) begin
          out_data_r.stick_x   <= nx_r ? (16'd0 - {1'b0, qx_r}) : {1'b0, qx_r};
          out_data_r.stick_y   <= ny_r ? (16'd0 - {1'b0, qy_r}) : {1'b0, qy_r};
          out_data_r.magnitude <= mag_r;
          out_data_r.pressed   <= pressed_r;
          out_data_r.held      <= held_r;
        end
      end
      default: ;
    endcase
  end

  logic [15:0] abs_x, abs_y;
  assign abs_x = out_data_r.stick_x[15] ? (16'd0 - out_data_r.stick_x) : out_data_r.stick_x;
  assign abs_y = out_data_r.stick_y[15] ? (16'd0 - out_data_r.stick_y) : out_data_r.stick_y;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input accepted twice without finishing the first item");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == asc_pkg::S_DIV |-> len_r != 16'd0)
    else $error("division started with a zero vector length");

  a_axis_within_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (abs_x <= {1'b0, out_data_r.magnitude})
                 && (abs_y <= {1'b0, out_data_r.magnitude}))
    else $error("an axis exceeds the reported vector length");

  a_mag_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.magnitude <= {radius_limit_r, 8'd0})
    else $error("magnitude exceeds the radius limit");

  a_pressed_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.pressed & ~out_data_r.held) == 16'd0)
    else $error("a pressed button is not held");

endmodule

[verif/analog_stick_conditioner_top_test.sv]
`timescale 1ns / 1ps

module analog_stick_conditioner_top_test;

  localparam int HOLD_CYCLES   = 500;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 120;
  localparam int BATCH_ITEMS   = 80;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  asc_pkg::asc_in_t               in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  asc_pkg::asc_out_t              out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [asc_pkg::CFG_IDX_W-1:0]  cfg_index = asc_pkg::REG_DEAD_ZONE;
  logic [asc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // Shadow copy of the block's settings and per-port held words.
  logic [asc_pkg::CFG_DATA_W-1:0] dz_now     = asc_pkg::DEAD_ZONE_RESET;
  logic [asc_pkg::CFG_DATA_W-1:0] offset_now = asc_pkg::CENTER_OFFSET_RESET;
  logic [asc_pkg::CFG_DATA_W-1:0] radius_now = asc_pkg::RADIUS_LIMIT_RESET;
  logic [15:0]                    held_word [asc_pkg::PORT_COUNT] = '{default: '0};

  asc_pkg::asc_out_t conditioned_q [$];
  int       fail_count   = 0;
  int       idle_cycles  = 0;
  int       send_gap_pct = 0;
  int       recv_gap_pct = 0;
  logic     hold_req     = 1'b0;

  always #10 clk = ~clk;

  analog_stick_conditioner_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic int axis_deflection(logic [7:0] raw);
    int a;
    a = raw[7] ? 256 - int'(raw) : int'(raw);
    if (a == 0 || a < int'(dz_now)) return 0;
    if (int'(offset_now) >= a) return 0;
    return a - int'(offset_now);
  endfunction

  // Works out the result of one sample and moves the held word of its port on.
  function automatic asc_pkg::asc_out_t condition_sample(asc_pkg::asc_in_t s);
    asc_pkg::asc_out_t r;
    longint unsigned   ax, ay, len, lim, nx, ny, qx, qy;
    r = '0;
    if (!s.present) begin
      held_word[s.port] = '0;
      return r;
    end
    ax  = axis_deflection(s.raw_x);
    ay  = axis_deflection(s.raw_y);
    len = ax * ax + ay * ay;
    lim = radius_now;
    if (len > lim * lim) begin
      // Scaled onto the circle; the root of the squared quotient truncates toward zero.
      nx = ax * lim * 256;
      ny = ay * lim * 256;
      qx = int_sqrt(nx * nx / len);
      qy = int_sqrt(ny * ny / len);
      r.magnitude = 15'(lim * 256);
    end else begin
      qx = ax * 256;
      qy = ay * 256;
      r.magnitude = 15'(int_sqrt(len << 16));
    end
    r.stick_x = s.raw_x[7] ? -16'(qx) : 16'(qx);
    r.stick_y = s.raw_y[7] ? -16'(qy) : 16'(qy);
    r.pressed = s.buttons & ~held_word[s.port];
    r.held    = s.buttons;
    held_word[s.port] = s.buttons;
    return r;
  endfunction

  function automatic asc_pkg::asc_in_t make_sample(int port, int present, int x, int y,
                                                   int buttons);
    asc_pkg::asc_in_t s;
    s.port    = asc_pkg::PORT_W'(port);
    s.present = 1'(present);
    s.raw_x   = 8'(x);
    s.raw_y   = 8'(y);
    s.buttons = 16'(buttons);
    return s;
  endfunction

  function automatic int random_axis();
    int mag;
    case ($urandom_range(3))
      0: return int'($urandom_range(255)) - 128;
      1: mag = int'(dz_now) + int'($urandom_range(4)) - 2;
      2: mag = $urandom_range(20);
      default: mag = 127 + $urandom_range(1);
    endcase
    if (mag < 0) mag = 0;
    if (mag > 128) mag = 128;
    if ($urandom_range(1) == 1) return -mag;
    return mag;
  endfunction

  function automatic asc_pkg::asc_in_t random_sample();
    asc_pkg::asc_in_t s;
    logic [15:0]      b;
    s.port    = asc_pkg::PORT_W'($urandom_range(asc_pkg::PORT_COUNT - 1));
    s.present = ($urandom_range(99) >= 8);
    s.raw_x   = 8'(random_axis());
    s.raw_y   = 8'(random_axis());
    // Mostly edits of the held word (toggle, set, clear), so that presses and releases mix.
    case ($urandom_range(3))
      0: b = 16'($urandom_range(16'hFFFF));
      1: b = held_word[s.port] ^ (16'd1 << $urandom_range(15));
      2: b = held_word[s.port] | 16'($urandom);
      default: b = held_word[s.port] & 16'($urandom);
    endcase
    s.buttons = b;
    return s;
  endfunction

  // Leaves valid high on return; the next call or wait_results decides what follows.
  task automatic send_sample(asc_pkg::asc_in_t s);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    conditioned_q.push_back(condition_sample(s));
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (conditioned_q.size() != 0);
  endtask

  task automatic write_reg(asc_pkg::reg_idx_t idx, logic [asc_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      asc_pkg::REG_DEAD_ZONE:     dz_now     = value;
      asc_pkg::REG_CENTER_OFFSET: offset_now = value;
      asc_pkg::REG_RADIUS_LIMIT:  radius_now = value;
      default: ;
    endcase
  endtask

  // Only called with no transaction outstanding.
  task automatic load_settings(int dz, int off, int lim);
    write_reg(asc_pkg::REG_DEAD_ZONE, asc_pkg::CFG_DATA_W'(dz));
    write_reg(asc_pkg::REG_CENTER_OFFSET, asc_pkg::CFG_DATA_W'(off));
    write_reg(asc_pkg::REG_RADIUS_LIMIT, asc_pkg::CFG_DATA_W'(lim));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_axis_extremes();
    send_sample(make_sample(0, 1, 127, 127, 'hFFFF));
    send_sample(make_sample(0, 1, -128, -128, 'h0000));
    send_sample(make_sample(1, 1, 127, -128, 'hA5A5));
    send_sample(make_sample(1, 1, 0, 0, 'h5A5A));
    send_sample(make_sample(0, 1, -1, 1, 'h8001));
    send_sample(make_sample(0, 1, 30, -40, 'h7FFE));
    wait_results();
  endtask

  task automatic test_dead_zone_edges();
    load_settings(asc_pkg::DEAD_ZONE_RESET, asc_pkg::CENTER_OFFSET_RESET,
                  asc_pkg::RADIUS_LIMIT_RESET);
    send_sample(make_sample(0, 1, 7, -8, 'h0F0F));
    send_sample(make_sample(1, 1, 8, -7, 'hF0F0));
    wait_results();
    // With no dead zone a centred axis must still read zero.
    load_settings(0, 0, 127);
    send_sample(make_sample(0, 1, 0, 1, 'h0001));
    send_sample(make_sample(1, 1, -1, 0, 'h8000));
    wait_results();
  endtask

  task automatic test_offset_above_dead_zone();
    load_settings(4, 20, 127);
    send_sample(make_sample(0, 1, 10, -19, 'h1111));
    send_sample(make_sample(0, 1, 20, -21, 'h2222));
    send_sample(make_sample(1, 1, -128, 5, 'h4444));
    wait_results();
  endtask

  task automatic test_radius_clamp();
    load_settings(0, 0, 0);
    send_sample(make_sample(0, 1, 5, -3, 'h0003));
    send_sample(make_sample(0, 1, 0, 0, 'h0300));
    wait_results();
    load_settings(127, 0, 1);
    send_sample(make_sample(1, 1, 127, -128, 'hFFFF));
    wait_results();
    load_settings(0, 127, 127);
    send_sample(make_sample(0, 1, -128, 127, 'hFFFE));
    wait_results();
  endtask

  task automatic test_absent_controller();
    load_settings(asc_pkg::DEAD_ZONE_RESET, asc_pkg::CENTER_OFFSET_RESET,
                  asc_pkg::RADIUS_LIMIT_RESET);
    send_sample(make_sample(0, 1, 50, 50, 'h00FF));
    send_sample(make_sample(0, 0, 50, 50, 'hFFFF));
    send_sample(make_sample(0, 1, 0, 0, 'h00FF));
    send_sample(make_sample(1, 0, -128, 127, 'h1234));
    wait_results();
  endtask

  task automatic test_random_samples(int per_batch);
    int dz, off, lim;
    for (int k = 0; k < 7; k++) begin
      case (k)
        0: begin dz = 8;   off = 6;   lim = 64;  end
        1: begin dz = 0;   off = 0;   lim = 127; end
        2: begin dz = 127; off = 0;   lim = 1;   end
        3: begin dz = 127; off = 127; lim = 127; end
        4: begin
          dz  = $urandom_range(40);
          off = $urandom_range(dz);
          lim = $urandom_range(127, 1);
        end
        5: begin
          dz  = $urandom_range(127);
          off = $urandom_range(127);
          lim = $urandom_range(127);
        end
        default: begin
          dz  = $urandom_range(20);
          off = $urandom_range(dz);
          lim = $urandom_range(127, 20);
        end
      endcase
      wait_results();
      load_settings(dz, off, lim);
      repeat (per_batch) send_sample(random_sample());
    end
    wait_results();
  endtask

  // The receiver stops for a long stretch while samples keep coming, so the input stalls.
  task automatic test_output_backpressure();
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (16) send_sample(random_sample());
    wait_results();
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  task automatic check_field(string field, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    asc_pkg::asc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (conditioned_q.size() == 0) begin
        $display("%0t: result transaction with none expected, expected nothing, actual %p",
                 $time, out_data);
        fail_count++;
      end else begin
        want = conditioned_q.pop_front();
        check_field("stick_x", $signed(want.stick_x), $signed(out_data.stick_x));
        check_field("stick_y", $signed(want.stick_y), $signed(out_data.stick_y));
        check_field("magnitude", want.magnitude, out_data.magnitude);
        check_field("pressed", want.pressed, out_data.pressed);
        check_field("held", want.held, out_data.held);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** analog_stick_conditioner_top: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gap_pct = 6;
    recv_gap_pct = 76;
    test_axis_extremes();
    test_dead_zone_edges();
    test_offset_above_dead_zone();
    test_radius_clamp();
    test_absent_controller();
    test_random_samples(BATCH_ITEMS);
    send_gap_pct = 76;
    recv_gap_pct = 6;
    test_random_samples(BATCH_ITEMS);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_samples(BATCH_ITEMS);
    test_output_backpressure();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** analog_stick_conditioner_top: PASSED **");
    end else begin
      $display("** analog_stick_conditioner_top: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/asc_pkg.sv
rtl/core/analog_stick_conditioner_top.sv
verif/analog_stick_conditioner_top_test.sv
